// ----- src/hashed_allocation_tracker_top_macros.svh -----
// Assertion macros used by the tracker datapath (hat_dp).
`ifndef HASHED_ALLOCATION_TRACKER_TOP_MACROS_SVH
`define HASHED_ALLOCATION_TRACKER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define HAT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hat assertion failed");
`define HAT_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("hat assertion failed");
`else
`define HAT_ASSERT(name, prop)
`define HAT_ASSERT_NEXT(name, pre, post)
`endif

`endif

// ----- src/hat_pkg.sv -----
package hat_pkg;

  localparam int unsigned BUCKETS      = 1009;
  localparam int unsigned BUCKET_DEPTH = 8;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned LINE_W    = 20;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned IDX_OUT_W = 10;

  localparam int unsigned BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SLOT_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned SLOTS  = BUCKETS * BUCKET_DEPTH;
  localparam int unsigned ENT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned ENT_W  = ADDR_W + LINE_W;

  localparam int unsigned MIX_STEPS = 7;
  localparam int unsigned DIG_W     = 8;
  localparam int unsigned N_DIG     = ADDR_W / DIG_W;
  localparam int unsigned STEP_W    = $clog2(N_DIG);

  localparam int unsigned XW      = BKT_W + DIG_W;
  localparam int unsigned RSH     = XW + BKT_W;
  localparam int unsigned RECIP_W = RSH + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RSH) / 64'(BUCKETS));

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_IGNORED   = 3'd4
  } status_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic mix;
    logic mod_a;
    logic mod_b;
    logic fill_rd;
    logic fill_ld;
    logic scan;
    logic last_rd;
    logic rm_wr;
    logic add_wr;
    logic out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mix_done;
    logic mod_done;
    logic scan_done;
    logic rm_hit;
    logic is_add;
    logic out_free;
  } dp_sts_t;

  function automatic logic [ADDR_W-1:0] mix_step(input logic [ADDR_W-1:0] a,
                                                 input logic [STEP_W-1:0] k);
    logic [ADDR_W-1:0] r;
    unique case (k)
      STEP_W'(0): r = (~a) + (a << 21);
      STEP_W'(1): r = a ^ (a >> 24);
      STEP_W'(2): r = (a + (a << 3)) + (a << 8);
      STEP_W'(3): r = a ^ (a >> 14);
      STEP_W'(4): r = (a + (a << 2)) + (a << 4);
      STEP_W'(5): r = a ^ (a >> 28);
      default:    r = a + (a << 31);
    endcase
    return r;
  endfunction

endpackage

// ----- src/hashed_allocation_tracker_top.sv -----
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_stall_o  operation_i, block_address_i, block_size_i,
//                                              source_line_i
// result    out        out_valid_o / out_stall_i status_o, duplicate_found_o, null_address_o,
//                                              bucket_index_o, earlier_line_o
//
// One request is processed at a time. Each request passes through the seven-step hash
// mix, the remainder unit (one byte of the hash per MOD_A and MOD_B step pair) and the
// bucket scan through the single read port of the entry memory.
// After reset a clearing pass zeroes the bucket fill memory, and requests are stalled
// until it ends. A new request is taken while a result waits in the output register;
// only the final hand-off to that register waits on out_stall_i.
module hashed_allocation_tracker_top import hat_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [ADDR_W-1:0]    block_address_i,
  input  logic [SIZE_W-1:0]    block_size_i,
  input  logic [LINE_W-1:0]    source_line_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 duplicate_found_o,
  output logic                 null_address_o,
  output logic [IDX_OUT_W-1:0] bucket_index_o,
  output logic [LINE_W-1:0]    earlier_line_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  hat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hat_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .operation_i       (operation_i),
    .block_address_i   (block_address_i),
    .block_size_i      (block_size_i),
    .source_line_i     (source_line_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .duplicate_found_o (duplicate_found_o),
    .null_address_o    (null_address_o),
    .bucket_index_o    (bucket_index_o),
    .earlier_line_o    (earlier_line_o)
  );

endmodule

// ----- src/hat_ctrl.sv -----
module hat_ctrl import hat_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_MIX     = 12'b0000_0000_0100,
    S_MOD_A   = 12'b0000_0000_1000,
    S_MOD_B   = 12'b0000_0001_0000,
    S_FILL_RD = 12'b0000_0010_0000,
    S_FILL_LD = 12'b0000_0100_0000,
    S_SCAN    = 12'b0000_1000_0000,
    S_RM_RD   = 12'b0001_0000_0000,
    S_RM_WR   = 12'b0010_0000_0000,
    S_ADD_WR  = 12'b0100_0000_0000,
    S_RESULT  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MIX;
        end
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        if (sts_i.mix_done) state_d = S_MOD_A;
      end
      S_MOD_A: begin
        cmd_o.mod_a = 1'b1;
        state_d     = S_MOD_B;
      end
      S_MOD_B: begin
        cmd_o.mod_b = 1'b1;
        state_d     = sts_i.mod_done ? S_FILL_RD : S_MOD_A;
      end
      S_FILL_RD: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = S_FILL_LD;
      end
      S_FILL_LD: begin
        cmd_o.fill_ld = 1'b1;
        state_d       = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          priority if (sts_i.rm_hit) state_d = S_RM_RD;
          else if (sts_i.is_add) state_d = S_ADD_WR;
          else state_d = S_RESULT;
        end
      end
      S_RM_RD: begin
        cmd_o.last_rd = 1'b1;
        state_d       = S_RM_WR;
      end
      S_RM_WR: begin
        cmd_o.rm_wr = 1'b1;
        state_d     = S_RESULT;
      end
      S_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/hat_dp.sv -----
`include "hashed_allocation_tracker_top_macros.svh"

module hat_dp import hat_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 operation_i,
  input  logic [ADDR_W-1:0]    block_address_i,
  input  logic [SIZE_W-1:0]    block_size_i,
  input  logic [LINE_W-1:0]    source_line_i,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 duplicate_found_o,
  output logic                 null_address_o,
  output logic [IDX_OUT_W-1:0] bucket_index_o,
  output logic [LINE_W-1:0]    earlier_line_o
);

  logic                op_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [SIZE_W-1:0]   size_q;
  logic [LINE_W-1:0]   line_q;
  logic [ADDR_W-1:0]   h_q;
  logic [STEP_W-1:0]   step_q;
  logic [BKT_W-1:0]    r_q;
  logic [XW-1:0]       q_q;
  logic [ENT_AW-1:0]   base_q;
  logic [FILL_W-1:0]   fill_q;
  logic [FILL_W-1:0]   idx_q;
  logic                rdv_q;
  logic [SLOT_W-1:0]   rd_slot_q;
  logic                hit_q;
  logic [SLOT_W-1:0]   hit_slot_q;
  logic [LINE_W-1:0]   earlier_q;
  logic                started_q;
  logic [BKT_W-1:0]    clr_q;
  logic                out_valid_q;

  logic [FILL_W-1:0]   fill_mem [BUCKETS];
  logic [FILL_W-1:0]   fill_rd_q;
  logic [ENT_W-1:0]    ent_mem [SLOTS];
  logic [SIZE_W-1:0]   size_mem [SLOTS];
  logic [ENT_W-1:0]    ent_rd_q;
  logic [SIZE_W-1:0]   size_rd_q;

  logic                      mix_done, mod_done, scan_done, scan_issue, match, has_room;
  logic [XW-1:0]             x;
  logic [XW+RECIP_W-1:0]     prod;
  logic [XW+BKT_W-1:0]       qm, rem_full, rem_adj;
  logic                      fill_we, ent_we, ent_re;
  logic [BKT_W-1:0]          fill_wa;
  logic [FILL_W-1:0]         fill_wd;
  logic [ENT_AW-1:0]         ent_ra, ent_wa;
  logic [ENT_W-1:0]          ent_wd;
  logic [SIZE_W-1:0]         size_wd;
  status_e                   status_d;

  assign mix_done = (step_q == STEP_W'(MIX_STEPS - 1));
  assign mod_done = (step_q == STEP_W'(N_DIG - 1));
  assign has_room = (fill_q < FILL_W'(BUCKET_DEPTH));

  // One radix-256 digit of the remainder per MOD_A/MOD_B pair: quotient estimate, then correction.
  assign x        = {r_q, h_q[ADDR_W-1 -: DIG_W]};
  assign prod     = (XW+RECIP_W)'(x) * (XW+RECIP_W)'(RECIP);
  assign qm       = (XW+BKT_W)'(q_q) * (XW+BKT_W)'(BUCKETS);
  assign rem_full = (XW+BKT_W)'(x) - qm;
  assign rem_adj  = (rem_full >= (XW+BKT_W)'(BUCKETS)) ?
                    rem_full - (XW+BKT_W)'(BUCKETS) : rem_full;

  assign scan_issue = cmd_i.scan && !hit_q && (idx_q < fill_q);
  assign match      = rdv_q && !hit_q && (ent_rd_q[ENT_W-1 -: ADDR_W] == addr_q);
  assign scan_done  = !rdv_q && (hit_q || (idx_q >= fill_q));

  assign fill_we = cmd_i.clr || (cmd_i.add_wr && has_room) || cmd_i.rm_wr;
  assign fill_wa = cmd_i.clr ? clr_q : r_q;
  always_comb begin
    priority if (cmd_i.clr) fill_wd = '0;
    else if (cmd_i.add_wr) fill_wd = fill_q + FILL_W'(1);
    else fill_wd = fill_q - FILL_W'(1);
  end

  assign ent_re  = scan_issue || cmd_i.last_rd;
  assign ent_ra  = base_q + (cmd_i.last_rd ? ENT_AW'(fill_q - FILL_W'(1)) : ENT_AW'(idx_q));
  assign ent_we  = (cmd_i.add_wr && has_room) || cmd_i.rm_wr;
  assign ent_wa  = base_q + (cmd_i.add_wr ? ENT_AW'(fill_q) : ENT_AW'(hit_slot_q));
  assign ent_wd  = cmd_i.add_wr ? {addr_q, line_q} : ent_rd_q;
  assign size_wd = cmd_i.add_wr ? size_q : size_rd_q;

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    if (cmd_i.fill_rd) fill_rd_q <= fill_mem[r_q];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_wa]  <= ent_wd;
      size_mem[ent_wa] <= size_wd;
    end
    if (ent_re) begin
      ent_rd_q  <= ent_mem[ent_ra];
      size_rd_q <= size_mem[ent_ra];
    end
  end

  always_comb begin
    if (op_q == OP_ADD) begin
      status_d = has_room ? ST_ADDED : ST_FULL;
    end else if (!started_q) begin
      status_d = ST_IGNORED;
    end else begin
      status_d = hit_q ? ST_REMOVED : ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      addr_q <= block_address_i;
      size_q <= block_size_i;
      line_q <= source_line_i;
      h_q    <= block_address_i;
    end else if (cmd_i.mix) begin
      h_q <= mix_step(h_q, step_q);
    end else if (cmd_i.mod_b) begin
      h_q <= h_q << DIG_W;
    end
    if (cmd_i.mod_a) q_q <= prod[RSH +: XW];
    if (cmd_i.fill_rd) base_q <= ENT_AW'(r_q) * ENT_AW'(BUCKET_DEPTH);
    if (cmd_i.scan) rd_slot_q <= SLOT_W'(idx_q);
    if (cmd_i.fill_ld) begin
      earlier_q <= '0;
    end else if (match) begin
      hit_slot_q <= rd_slot_q;
      earlier_q  <= ent_rd_q[LINE_W-1:0];
    end
    if (cmd_i.out_ld) begin
      status_o          <= status_d;
      duplicate_found_o <= (op_q == OP_ADD) && hit_q;
      null_address_o    <= (op_q == OP_ADD) && (addr_q == '0);
      bucket_index_o    <= IDX_OUT_W'(r_q);
      earlier_line_o    <= ((op_q == OP_ADD) && hit_q) ? earlier_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      r_q         <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      rdv_q       <= 1'b0;
      hit_q       <= 1'b0;
      started_q   <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        step_q <= '0;
      end else if (cmd_i.mix) begin
        step_q <= mix_done ? '0 : step_q + STEP_W'(1);
        if (mix_done) r_q <= '0;
      end else if (cmd_i.mod_b) begin
        step_q <= mod_done ? '0 : step_q + STEP_W'(1);
        r_q    <= BKT_W'(rem_adj);
      end
      if (cmd_i.fill_ld) begin
        fill_q <= fill_rd_q;
        idx_q  <= '0;
        rdv_q  <= 1'b0;
        hit_q  <= 1'b0;
      end else if (cmd_i.scan) begin
        rdv_q <= scan_issue;
        if (scan_issue) idx_q <= idx_q + FILL_W'(1);
        if (match) hit_q <= 1'b1;
      end
      if (cmd_i.add_wr) started_q <= 1'b1;
      if (cmd_i.clr) clr_q <= clr_q + BKT_W'(1);
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.clr_done  = (32'(clr_q) == BUCKETS - 1);
  assign sts_o.mix_done  = mix_done;
  assign sts_o.mod_done  = mod_done;
  assign sts_o.scan_done = scan_done;
  assign sts_o.rm_hit    = (op_q == OP_REMOVE) && hit_q;
  assign sts_o.is_add    = (op_q == OP_ADD);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  `HAT_ASSERT(a_bucket_range, 32'(r_q) < BUCKETS)
  `HAT_ASSERT(a_fill_bound, fill_we |-> (32'(fill_wd) <= BUCKET_DEPTH))
  `HAT_ASSERT(a_hit_in_fill, hit_q |-> (32'(hit_slot_q) < 32'(fill_q)))
  `HAT_ASSERT_NEXT(a_digit_wrap, cmd_i.mod_b && mod_done, step_q == '0)

endmodule

// ----- verif/hashed_allocation_tracker_top_tb.sv -----
`timescale 1ns / 100ps

module hashed_allocation_tracker_top_tb;
  import hat_pkg::*;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [LINE_W-1:0] line;
  } request_t;

  typedef struct packed {
    status_e              status;
    logic                 dup;
    logic                 nul;
    logic [IDX_OUT_W-1:0] bucket;
    logic [LINE_W-1:0]    earlier;
  } verdict_t;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = 1'b0;
  logic [ADDR_W-1:0] block_address_i = '0;
  logic [SIZE_W-1:0] block_size_i = '0;
  logic [LINE_W-1:0] source_line_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic duplicate_found_o;
  logic null_address_o;
  logic [IDX_OUT_W-1:0] bucket_index_o;
  logic [LINE_W-1:0] earlier_line_o;

  request_t pending_requests[$];
  verdict_t expected_verdicts[$];
  logic [ADDR_W-1:0] live_addrs[$];

  logic [ADDR_W-1:0] tbl_addr[BUCKETS][BUCKET_DEPTH];
  logic [LINE_W-1:0] tbl_line[BUCKETS][BUCKET_DEPTH];
  int unsigned tbl_fill[BUCKETS];
  bit tracking_started;

  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_phase;
  bit stimulus_done;

  hashed_allocation_tracker_top dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int unsigned hash_bucket(logic [ADDR_W-1:0] a);
    a = (~a) + (a << 21);
    a = a ^ (a >> 24);
    a = (a + (a << 3)) + (a << 8);
    a = a ^ (a >> 14);
    a = (a + (a << 2)) + (a << 4);
    a = a ^ (a >> 28);
    a = a + (a << 31);
    return int'(a % 64'(BUCKETS));
  endfunction

  function automatic verdict_t track_request(request_t r);
    verdict_t v;
    int unsigned b;
    int hit;
    int unsigned last;
    b = hash_bucket(r.addr);
    hit = -1;
    v = '0;
    v.bucket = IDX_OUT_W'(b);
    for (int i = 0; i < int'(tbl_fill[b]); i++) begin
      if (hit < 0 && tbl_addr[b][i] == r.addr) begin
        hit = i;
      end
    end
    if (r.op == OP_ADD) begin
      tracking_started = 1'b1;
      v.nul = (r.addr == '0);
      if (hit >= 0) begin
        v.dup = 1'b1;
        v.earlier = tbl_line[b][hit];
      end
      if (tbl_fill[b] >= BUCKET_DEPTH) begin
        v.status = ST_FULL;
      end else begin
        tbl_addr[b][tbl_fill[b]] = r.addr;
        tbl_line[b][tbl_fill[b]] = r.line;
        tbl_fill[b]++;
        v.status = ST_ADDED;
      end
    end else if (!tracking_started) begin
      v.status = ST_IGNORED;
    end else if (hit >= 0) begin
      last = tbl_fill[b] - 1;
      tbl_addr[b][hit] = tbl_addr[b][last];
      tbl_line[b][hit] = tbl_line[b][last];
      tbl_fill[b]--;
      v.status = ST_REMOVED;
    end else begin
      v.status = ST_NOT_FOUND;
    end
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] random_addr();
    logic [ADDR_W-1:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: a = '0;
      1: a = '1;
      2: a = a & 64'hFFFF;
      default: ;
    endcase
    return a;
  endfunction

  // Finds an address that lands in the given bucket.
  function automatic logic [ADDR_W-1:0] addr_in_bucket(int unsigned b);
    logic [ADDR_W-1:0] a;
    do begin
      a = {$urandom, $urandom};
    end while (hash_bucket(a) != b);
    return a;
  endfunction

  task automatic queue_request(logic op, logic [ADDR_W-1:0] addr);
    request_t r;
    r.op = op;
    r.addr = addr;
    r.size = $urandom;
    r.line = LINE_W'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      r.size = $urandom_range(0, 1) ? '1 : '0;
      r.line = $urandom_range(0, 1) ? '1 : '0;
    end
    if (op == OP_ADD) begin
      live_addrs.push_back(addr);
    end
    pending_requests.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  initial begin
    logic [ADDR_W-1:0] crowded[$];
    int unsigned b;
    int unsigned k;
    queue_request(OP_REMOVE, 64'h1234);
    queue_request(OP_REMOVE, '1);
    queue_request(OP_ADD, '0);
    queue_request(OP_ADD, '0);
    queue_request(OP_ADD, '1);
    queue_request(OP_REMOVE, '0);
    queue_request(OP_REMOVE, '0);
    queue_request(OP_REMOVE, '0);
    queue_request(OP_REMOVE, 64'h5555_AAAA_5555_AAAA);
    b = $urandom_range(0, BUCKETS - 1);
    for (int i = 0; i < BUCKET_DEPTH; i++) begin
      crowded.push_back(addr_in_bucket(b));
      queue_request(OP_ADD, crowded[i]);
    end
    queue_request(OP_ADD, crowded[0]);
    queue_request(OP_ADD, addr_in_bucket(b));
    queue_request(OP_REMOVE, crowded[2]);
    queue_request(OP_REMOVE, crowded[BUCKET_DEPTH - 1]);
    queue_request(OP_ADD, crowded[3]);
    for (int i = 0; i < 1150; i++) begin
      k = $urandom_range(0, 99);
      if (k < 40 || live_addrs.size() == 0) begin
        queue_request(OP_ADD, random_addr());
      end else if (k < 75) begin
        queue_request(OP_REMOVE, live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
      end else if (k < 85) begin
        queue_request(OP_ADD, live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
      end else if (k < 93) begin
        queue_request(OP_ADD, addr_in_bucket(b));
      end else begin
        queue_request(OP_REMOVE, random_addr());
      end
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_verdicts.push_back(track_request(pending_requests.pop_front()));
      end
      if (in_valid_i && in_stall_o) begin
      end else if (pending_requests.size() != 0 && burst_left != 0) begin
        in_valid_i <= 1'b1;
        operation_i <= pending_requests[0].op;
        block_address_i <= pending_requests[0].addr;
        block_size_i <= pending_requests[0].size;
        source_line_i <= pending_requests[0].line;
        burst_left--;
      end else begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      stall_phase++;
      out_stall_i <= (stall_phase % 400 > 150) && ($urandom_range(0, 2) != 0);
      if (out_valid_o && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result", 32'(status_o), 32'hFFFF_FFFF);
        end else begin
          want = expected_verdicts.pop_front();
          if (status_o !== want.status) begin
            report_mismatch("status", 32'(status_o), 32'(want.status));
          end
          if (duplicate_found_o !== want.dup) begin
            report_mismatch("duplicate", 32'(duplicate_found_o), 32'(want.dup));
          end
          if (null_address_o !== want.nul) begin
            report_mismatch("null", 32'(null_address_o), 32'(want.nul));
          end
          if (bucket_index_o !== want.bucket) begin
            report_mismatch("bucket", 32'(bucket_index_o), 32'(want.bucket));
          end
          if (earlier_line_o !== want.earlier) begin
            report_mismatch("earlier line", 32'(earlier_line_o), 32'(want.earlier));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    wait (rst_ni);
    wait (pending_requests.size() == 0 && expected_verdicts.size() == 0);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
